[design/hrlp_pkg.sv]
// Shared types, character constants and the per-byte field update of the request-line parser.
package hrlp_pkg;

	localparam int LEN_W = 14;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_SP = 8'h20;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

	localparam logic [3:0] VER_LEN = 4'd8;
	localparam logic [3:0] VPOS_MAX = 4'd15;

	// "HTTP/1.0" and "HTTP/1.1"
	localparam logic [7:0] VER10 [8] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h30};
	localparam logic [7:0] VER11 [8] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31};

	typedef enum logic [1:0] {
		PH_METHOD,
		PH_TARGET,
		PH_VERSION
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_METHOD,
		KIND_TARGET,
		KIND_VERSION
	} kind_t;

	typedef enum logic [2:0] {
		ST_BUSY,
		ST_DONE,
		ST_NO_DELIM,
		ST_BAD_METHOD,
		ST_BAD_VERSION
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]       field_kind;
		logic [7:0]       field_byte;
		logic [2:0]       status;
		logic             minor_version;
		logic [LEN_W-1:0] line_length;
	} out_beat_t;

	// vmatch[0]: still matches HTTP/1.0, vmatch[1]: still matches HTTP/1.1
	typedef struct packed {
		phase_t     phase;
		logic       prev_cr;
		logic       method_bad;
		logic [3:0] vpos;
		logic [1:0] vmatch;
	} line_state_t;

	localparam line_state_t LINE_CLEAR = '{
		phase: PH_METHOD,
		prev_cr: 1'b0,
		method_bad: 1'b0,
		vpos: 4'd0,
		vmatch: 2'b11
	};

	// Fold one data byte into the field that the current phase selects.
	function automatic line_state_t feed_data(line_state_t s, logic [7:0] b);
		line_state_t r;
		r = s;
		case (s.phase)
			PH_METHOD: begin
				if (b < CHAR_UPPER_A || b > CHAR_UPPER_Z)
					r.method_bad = 1'b1;
			end
			PH_TARGET: begin
				r.method_bad = s.method_bad;
			end
			default: begin
				if (s.vpos < VER_LEN) begin
					if (b != VER10[s.vpos[2:0]])
						r.vmatch[0] = 1'b0;
					if (b != VER11[s.vpos[2:0]])
						r.vmatch[1] = 1'b0;
				end else begin
					r.vmatch = 2'b00;
				end
				if (s.vpos < VPOS_MAX)
					r.vpos = s.vpos + 4'd1;
			end
		endcase
		return r;
	endfunction

endpackage

[design/hrlp_step.sv]
// Combinational next-state and result logic for one byte of a request line.
module hrlp_step #(
	parameter int MAX_LINE = 8192,
	parameter int CNT_W = 14
) (
	input  hrlp_pkg::in_beat_t    beat,
	input  hrlp_pkg::line_state_t cur_state,
	input  logic [CNT_W-1:0]      cur_count,
	output hrlp_pkg::line_state_t nxt_state,
	output logic [CNT_W-1:0]      nxt_count,
	output hrlp_pkg::out_beat_t   result
);

	hrlp_pkg::line_state_t eff_state;
	hrlp_pkg::line_state_t work_state;
	logic [CNT_W-1:0]      eff_count;
	logic [CNT_W-1:0]      cnt_inc;
	logic [7:0]            b;

	assign b = beat.data_byte;

	always_comb begin
		eff_state = beat.restart ? hrlp_pkg::LINE_CLEAR : cur_state;
		eff_count = beat.restart ? '0 : cur_count;
		cnt_inc   = (eff_count < CNT_W'(MAX_LINE)) ? eff_count + CNT_W'(1) : eff_count;

		work_state           = eff_state;
		nxt_state            = eff_state;
		nxt_count            = cnt_inc;
		result.field_kind    = hrlp_pkg::KIND_NONE;
		result.field_byte    = b;
		result.status        = hrlp_pkg::ST_BUSY;
		result.minor_version = 1'b0;
		result.line_length   = '0;

		if (eff_state.prev_cr && b == hrlp_pkg::CHAR_LF) begin
			// end of line: report and start over
			if (eff_state.phase == hrlp_pkg::PH_METHOD || eff_state.phase == hrlp_pkg::PH_TARGET)
				result.status = hrlp_pkg::ST_NO_DELIM;
			else if (eff_state.method_bad)
				result.status = hrlp_pkg::ST_BAD_METHOD;
			else if (eff_state.vpos != hrlp_pkg::VER_LEN || eff_state.vmatch == 2'b00)
				result.status = hrlp_pkg::ST_BAD_VERSION;
			else begin
				result.status        = hrlp_pkg::ST_DONE;
				result.minor_version = eff_state.vmatch[1];
				result.line_length   = hrlp_pkg::LEN_W'(cnt_inc);
			end
			nxt_state = hrlp_pkg::LINE_CLEAR;
			nxt_count = '0;
		end else begin
			// a held CR that was not followed by LF is plain data
			if (eff_state.prev_cr)
				work_state = hrlp_pkg::feed_data(eff_state, hrlp_pkg::CHAR_CR);
			work_state.prev_cr = 1'b0;
			nxt_state = work_state;
			if (b == hrlp_pkg::CHAR_CR) begin
				nxt_state.prev_cr = 1'b1;
			end else if (b == hrlp_pkg::CHAR_SP &&
					(work_state.phase == hrlp_pkg::PH_METHOD ||
					 work_state.phase == hrlp_pkg::PH_TARGET)) begin
				nxt_state.phase = hrlp_pkg::phase_t'(work_state.phase + 2'd1);
			end else begin
				nxt_state = hrlp_pkg::feed_data(work_state, b);
				case (work_state.phase)
					hrlp_pkg::PH_METHOD: result.field_kind = hrlp_pkg::KIND_METHOD;
					hrlp_pkg::PH_TARGET: result.field_kind = hrlp_pkg::KIND_TARGET;
					default:             result.field_kind = hrlp_pkg::KIND_VERSION;
				endcase
			end
		end
	end

endmodule

[design/http_request_line_parser.sv]
// Top level of the HTTP request-line parser: input stage, line state and result register.
//
// Parses an HTTP request line one byte per beat. Every accepted byte yields exactly one
// result beat: the byte echoed with a tag for its field (method, target, version, or none
// for delimiters and CR/LF), and a status that stays "in progress" until CR LF closes the line.
// At CR LF the status reports, in priority order, a missing space, a method byte that is
// not an uppercase letter, or a version other than HTTP/1.0 or HTTP/1.1; a good line
// reports the minor version and the line length including CR LF, saturating at MAX_LINE
// and carried in 14 bits. Any final status restarts the parser; setting restart on a byte
// discards the partial line first. Throughput is one byte per clock cycle with back-to-back
// beats while the result side accepts; the line state register loops through the step logic.
// Each byte passes the input register, then the result register, before its result is valid;
// a stalled result side backs up through both stages before byte_ready drops.
module http_request_line_parser #(
	parameter int MAX_LINE = 8192
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  hrlp_pkg::in_beat_t  byte_beat,
	output logic                res_valid,
	input  logic                res_ready,
	output hrlp_pkg::out_beat_t res_beat
);

	localparam int CNT_W = $clog2(MAX_LINE + 1);

	// input stage
	logic                  valid_s1;
	hrlp_pkg::in_beat_t    beat_s1;
	// result stage
	logic                  valid_s2;
	hrlp_pkg::out_beat_t   beat_s2;
	// line state
	hrlp_pkg::line_state_t state_q;
	logic [CNT_W-1:0]      count_q;

	hrlp_pkg::line_state_t state_nxt;
	logic [CNT_W-1:0]      count_nxt;
	hrlp_pkg::out_beat_t   step_res;

	logic ready_s1;
	logic advance_s1;

	// advance the input stage whenever the result register is free or draining
	assign ready_s1   = !valid_s2 || res_ready;
	assign advance_s1 = valid_s1 && ready_s1;
	assign byte_ready = !valid_s1 || ready_s1;

	hrlp_step #(
		.MAX_LINE(MAX_LINE),
		.CNT_W   (CNT_W)
	) u_step (
		.beat     (beat_s1),
		.cur_state(state_q),
		.cur_count(count_q),
		.nxt_state(state_nxt),
		.nxt_count(count_nxt),
		.result   (step_res)
	);

	// capture a new byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid)
			beat_s1 <= byte_beat;
	end

	// update line state and load the result when the stage advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= hrlp_pkg::LINE_CLEAR;
			count_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance_s1) begin
				state_q <= state_nxt;
				count_q <= count_nxt;
			end
			if (ready_s1)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1)
			beat_s2 <= step_res;
	end

	assign res_valid = valid_s2;
	assign res_beat  = beat_s2;

	// hold the input stage while the result side stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s1 |=> valid_s1 && $stable(beat_s1))
		else $error("input stage changed while stalled");

	// a final status leaves the line state cleared
	a_clear_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && step_res.status != hrlp_pkg::ST_BUSY
		|=> state_q == hrlp_pkg::LINE_CLEAR && count_q == '0)
		else $error("line state not cleared after final status");

	// minor version and length are reported only on a good line
	a_len_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_beat.status != hrlp_pkg::ST_DONE
		|-> res_beat.minor_version == 1'b0 && res_beat.line_length == '0)
		else $error("length or version reported without done");

	// a consumed CR is always held pending the next byte
	a_cr_pending: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && beat_s1.data_byte == hrlp_pkg::CHAR_CR |=> state_q.prev_cr)
		else $error("CR not held as pending");

endmodule
